@@ src/mer_pkg.sv @@
// Shared constants and types for the midpoint ellipse rasterizer.
package mer_pkg;

  localparam int AXIS_BITS_DEF  = 10;
  localparam int COORD_BITS_DEF = 12;

  // Fixed field widths
  localparam int OUT_W       = 14;
  localparam int COLOR_W     = 24;
  localparam int CFG_DW      = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 8;
  // 8 coordinates + color: 136 bits, already whole bytes
  localparam int OUT_TDATA_W = 8 * OUT_W + COLOR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_AXIS_A   = 3'd2,
    CFG_AXIS_B   = 3'd3,
    CFG_COLOR    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQ,
    ST_PROD,
    ST_CMP,
    ST_LOAD,
    ST_EMIT
  } seq_state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ONE,
    PH_TWO
  } phase_e;

  // Setup products, issued in this order on the shared multiplier
  typedef enum logic [2:0] {
    OP_A2,
    OP_B2,
    OP_A2B,
    OP_B2A,
    OP_A4,
    OP_B4,
    OP_DONE
  } mul_op_e;

endpackage

@@ src/mer_mul.sv @@
// Shared unsigned multiplier with registered product.
module mer_mul
  import mer_pkg::*;
#(
  parameter int W = 2 * AXIS_BITS_DEF + 1
) (
  input  logic           clk_i,
  input  logic [W-1:0]   op_a_i,
  input  logic [W-1:0]   op_b_i,
  output logic [2*W-1:0] prod_o
);

  logic [2*W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= (2*W)'(op_a_i) * (2*W)'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule

@@ src/midpoint_ellipse_raster_top.sv @@
// Top level of the midpoint ellipse rasterizer: config, sequencer, step datapath.
//
//  channel   | dir | transaction                       | payload
//  ----------+-----+-----------------------------------+------------------------------------
//  s_axis    | in  | tick: restart or advance one step | tdata[0] restart, [7:1] zero
//  m_axis    | out | four symmetric pixels of one step | tdata: 8 x 14b coords, 24b color;
//            |     |                                   | tlast = final step of region two
//  cfg       | in  | register write, no read-back      | cfg_idx_i, cfg_data_i
//
// Advance ticks stream steps at one per clock while m_axis keeps up. A restart tick
// runs the setup on one shared multiplier: 6 products, then two bit-serial bound
// searches, each bit passing through the square, product and compare states, then
// load and emit; the first pixel set is held in the emit state while an earlier
// result still waits in the output register with m_axis stalled.
// s_axis is not ready during setup, nor while a result sits unread in the output
// register and m_axis_tready is low. Reset leaves the block idle: advance ticks are
// taken and give nothing until a restart.
module midpoint_ellipse_raster_top
  import mer_pkg::*;
#(
  parameter int AXIS_BITS  = AXIS_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // restart (bit 0), zero fill
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // px_pp, py_pp, px_mp, py_mp, px_pm, py_pm, px_mm, py_mm, color_out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DW-1:0]      cfg_data_i
);

  localparam int A    = AXIS_BITS;
  localparam int SQ_W = 2 * A;               // a*a
  localparam int S_W  = 2 * A + 1;           // a*a + b*b
  localparam int MW   = 2 * A + 1;           // multiplier operand
  localparam int PW   = 2 * MW;              // multiplier product
  localparam int DW   = 4 * A + 3;           // decision and increments
  localparam int SW   = A + 2;               // signed step offsets
  localparam int KW   = $clog2(A);
  localparam int EW   = OUT_W + COORD_BITS + A;

  // ---------------- configuration registers ----------------
  logic [COORD_BITS-1:0] cfg_cx_q, cfg_cy_q;
  logic [A-1:0]          cfg_a_q, cfg_b_q;
  logic [COLOR_W-1:0]    cfg_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cx_q    <= '0;
      cfg_cy_q    <= '0;
      cfg_a_q     <= A'(1);
      cfg_b_q     <= A'(1);
      cfg_color_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_X: cfg_cx_q    <= cfg_data_i[COORD_BITS-1:0];
        CFG_CENTER_Y: cfg_cy_q    <= cfg_data_i[COORD_BITS-1:0];
        CFG_AXIS_A:   cfg_a_q     <= cfg_data_i[A-1:0];
        CFG_AXIS_B:   cfg_b_q     <= cfg_data_i[A-1:0];
        CFG_COLOR:    cfg_color_q <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- state ----------------
  seq_state_e state_q, state_d;
  phase_e     phase_q, phase_d;
  mul_op_e    op_q, op_d;
  logic [KW-1:0] k_q, k_d;
  logic          sel_q, sel_d;
  logic [A-1:0]  res_q, res_d;
  logic [A-1:0]  bnd1_q, bnd1_d, bnd2_q, bnd2_d;
  logic [A-1:0]  lat_a_q, lat_a_d, lat_b_q, lat_b_d;
  logic [SQ_W-1:0] a2_q, a2_d, b2_q, b2_d;
  logic [3*A-1:0]  a2b_q, a2b_d, b2a_q, b2a_d;
  logic [4*A-1:0]  a4_q, a4_d, b4_q, b4_d;
  logic signed [SW-1:0] x_q, x_d, y_q, y_d;
  logic signed [DW-1:0] dec_q, dec_d, is_q, is_d, id_q, id_d;
  logic signed [DW-1:0] r2_dec_q, r2_dec_d, r2_is_q, r2_is_d, r2_id_q, r2_id_d;
  logic signed [DW-1:0] sum2_q, sum2_d;

  // output register
  logic               ovalid_q, ovalid_d;
  logic [OUT_W-1:0]   px_pp_q, py_pp_q, px_mp_q, py_mp_q;
  logic [OUT_W-1:0]   px_pm_q, py_pm_q, px_mm_q, py_mm_q;
  logic [COLOR_W-1:0] color_q;
  logic               last_q;

  // ---------------- shared multiplier ----------------
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_q;

  mer_mul #(
    .W (MW)
  ) u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (mul_q)
  );

  // ---------------- bound search helpers ----------------
  logic [S_W-1:0]  s_sum;
  logic [A-1:0]    trial;
  logic [A-1:0]    lat_p;
  logic [4*A-1:0]  target;
  logic            trial_ok;

  assign s_sum    = S_W'(a2_q) + S_W'(b2_q);
  assign trial    = res_q | (A'(1) << k_q);
  assign lat_p    = sel_q ? lat_b_q : lat_a_q;
  assign target   = sel_q ? b4_q : a4_q;
  // n*n*(p*p+q*q) <= p^4 and n <= p
  assign trial_ok = (trial <= lat_p) && (mul_q <= PW'(target));

  // ---------------- step datapath ----------------
  logic                 step_en;
  logic                 emit;
  logic                 last_d;
  logic                 diag;
  logic signed [DW-1:0] two_q2;
  logic signed [SW-1:0] nx, ny;
  logic signed [SW-1:0] bnd1_e, bnd2_e;
  logic signed [EW-1:0] cx_e, cy_e, x_e, y_e;
  logic signed [EW-1:0] cxp, cxm, cyp, cym;

  assign diag   = ~dec_q[DW-1];
  assign two_q2 = (phase_q == PH_TWO) ? (DW'(a2_q) << 1) : (DW'(b2_q) << 1);
  assign bnd1_e = $signed({2'b00, bnd1_q});
  assign bnd2_e = $signed({2'b00, bnd2_q});

  assign cx_e = $signed(EW'(cfg_cx_q));
  assign cy_e = $signed(EW'(cfg_cy_q));
  assign x_e  = EW'(x_q);
  assign y_e  = EW'(y_q);
  assign cxp  = cx_e + x_e;
  assign cxm  = cx_e - x_e;
  assign cyp  = cy_e + y_e;
  assign cym  = cy_e - y_e;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    op_d     = op_q;
    k_d      = k_q;
    sel_d    = sel_q;
    res_d    = res_q;
    bnd1_d   = bnd1_q;
    bnd2_d   = bnd2_q;
    lat_a_d  = lat_a_q;
    lat_b_d  = lat_b_q;
    a2_d     = a2_q;
    b2_d     = b2_q;
    a2b_d    = a2b_q;
    b2a_d    = b2a_q;
    a4_d     = a4_q;
    b4_d     = b4_q;
    x_d      = x_q;
    y_d      = y_q;
    dec_d    = dec_q;
    is_d     = is_q;
    id_d     = id_q;
    r2_dec_d = r2_dec_q;
    r2_is_d  = r2_is_q;
    r2_id_d  = r2_id_q;
    sum2_d   = sum2_q;
    mul_a    = '0;
    mul_b    = '0;
    step_en  = 1'b0;
    last_d   = 1'b0;
    nx       = x_q;
    ny       = y_q;
    s_axis_tready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = !ovalid_q || m_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
          if (s_axis_tdata[0]) begin
            lat_a_d = cfg_a_q;
            lat_b_d = cfg_b_q;
            op_d    = OP_A2;
            state_d = ST_MUL;
          end else if (phase_q != PH_IDLE) begin
            step_en = 1'b1;
          end
        end
      end

      ST_MUL: begin
        // issue current product
        case (op_q)
          OP_A2:  begin mul_a = MW'(lat_a_q); mul_b = MW'(lat_a_q); end
          OP_B2:  begin mul_a = MW'(lat_b_q); mul_b = MW'(lat_b_q); end
          OP_A2B: begin mul_a = MW'(a2_q);    mul_b = MW'(lat_b_q); end
          OP_B2A: begin mul_a = MW'(b2_q);    mul_b = MW'(lat_a_q); end
          OP_A4:  begin mul_a = MW'(a2_q);    mul_b = MW'(a2_q);    end
          OP_B4:  begin mul_a = MW'(b2_q);    mul_b = MW'(b2_q);    end
          default: ;
        endcase
        // capture the one issued last cycle
        if (op_q != OP_A2) begin
          case (mul_op_e'(op_q - 3'd1))
            OP_A2:  a2_d  = mul_q[SQ_W-1:0];
            OP_B2:  b2_d  = mul_q[SQ_W-1:0];
            OP_A2B: a2b_d = mul_q[3*A-1:0];
            OP_B2A: b2a_d = mul_q[3*A-1:0];
            OP_A4:  a4_d  = mul_q[4*A-1:0];
            OP_B4:  b4_d  = mul_q[4*A-1:0];
            default: ;
          endcase
        end
        if (op_q == OP_DONE) begin
          sel_d   = 1'b0;
          res_d   = '0;
          k_d     = KW'(A - 1);
          state_d = ST_SQ;
        end else begin
          op_d = mul_op_e'(op_q + 3'd1);
        end
      end

      ST_SQ: begin
        mul_a   = MW'(trial);
        mul_b   = MW'(trial);
        state_d = ST_PROD;
      end

      ST_PROD: begin
        mul_a   = MW'(mul_q[SQ_W-1:0]);
        mul_b   = MW'(s_sum);
        state_d = ST_CMP;
      end

      ST_CMP: begin
        if (trial_ok) begin
          res_d = trial;
        end
        if (k_q == '0) begin
          if (!sel_q) begin
            bnd1_d  = trial_ok ? trial : res_q;
            sel_d   = 1'b1;
            res_d   = '0;
            k_d     = KW'(A - 1);
            state_d = ST_SQ;
          end else begin
            bnd2_d  = trial_ok ? trial : res_q;
            state_d = ST_LOAD;
          end
        end else begin
          k_d     = k_q - KW'(1);
          state_d = ST_SQ;
        end
      end

      ST_LOAD: begin
        // region one: p = a, q = b
        x_d   = '0;
        y_d   = SW'(lat_b_q);
        dec_d = DW'(b2_q) - DW'(a2b_q);
        is_d  = (DW'(b2_q) << 1) + DW'(b2_q);
        id_d  = (DW'(b2_q) << 1) + DW'(b2_q) + (DW'(a2_q) << 1) - (DW'(a2b_q) << 1);
        // region two: p = b, q = a
        r2_dec_d = DW'(a2_q) - DW'(b2a_q);
        r2_is_d  = (DW'(a2_q) << 1) + DW'(a2_q);
        r2_id_d  = (DW'(a2_q) << 1) + DW'(a2_q) + (DW'(b2_q) << 1) - (DW'(b2a_q) << 1);
        sum2_d   = (DW'(a2_q) << 1) + (DW'(b2_q) << 1);
        phase_d  = PH_ONE;
        state_d  = ST_EMIT;
      end

      ST_EMIT: begin
        // first pixel set waits until the output register is free
        if (!ovalid_q || m_axis_tready) begin
          step_en = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // one midpoint step from the current offset
    if (step_en) begin
      dec_d = dec_q + (diag ? id_q : is_q);
      is_d  = is_q + two_q2;
      id_d  = id_q + (diag ? sum2_q : two_q2);
      if (phase_q == PH_ONE) begin
        nx = x_q + SW'(1);
        ny = diag ? (y_q - SW'(1)) : y_q;
        if (nx > bnd1_e) begin
          x_d     = SW'(lat_a_q);
          y_d     = '0;
          dec_d   = r2_dec_q;
          is_d    = r2_is_q;
          id_d    = r2_id_q;
          phase_d = PH_TWO;
        end else begin
          x_d = nx;
          y_d = ny;
        end
      end else begin
        ny  = y_q + SW'(1);
        nx  = diag ? (x_q - SW'(1)) : x_q;
        x_d = nx;
        y_d = ny;
        if (ny > bnd2_e) begin
          last_d  = 1'b1;
          phase_d = PH_IDLE;
        end
      end
    end
  end

  assign emit     = step_en;
  assign ovalid_d = emit | (ovalid_q & ~m_axis_tready);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= PH_IDLE;
      op_q     <= OP_A2;
      k_q      <= '0;
      sel_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      op_q     <= op_d;
      k_q      <= k_d;
      sel_q    <= sel_d;
      ovalid_q <= ovalid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    bnd1_q   <= bnd1_d;
    bnd2_q   <= bnd2_d;
    lat_a_q  <= lat_a_d;
    lat_b_q  <= lat_b_d;
    a2_q     <= a2_d;
    b2_q     <= b2_d;
    a2b_q    <= a2b_d;
    b2a_q    <= b2a_d;
    a4_q     <= a4_d;
    b4_q     <= b4_d;
    x_q      <= x_d;
    y_q      <= y_d;
    dec_q    <= dec_d;
    is_q     <= is_d;
    id_q     <= id_d;
    r2_dec_q <= r2_dec_d;
    r2_is_q  <= r2_is_d;
    r2_id_q  <= r2_id_d;
    sum2_q   <= sum2_d;
    if (emit) begin
      px_pp_q <= cxp[OUT_W-1:0];
      py_pp_q <= cyp[OUT_W-1:0];
      px_mp_q <= cxm[OUT_W-1:0];
      py_mp_q <= cyp[OUT_W-1:0];
      px_pm_q <= cxp[OUT_W-1:0];
      py_pm_q <= cym[OUT_W-1:0];
      px_mm_q <= cxm[OUT_W-1:0];
      py_mm_q <= cym[OUT_W-1:0];
      color_q <= cfg_color_q;
      last_q  <= last_d;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {color_q, py_mm_q, px_mm_q, py_pm_q, px_pm_q,
                          py_mp_q, px_mp_q, py_pp_q, px_pp_q};
  assign m_axis_tlast  = last_q;

endmodule
